// File: hw/rtl/ps2mt_pkg.sv
// shared types, constants and helper functions for the ps/2 mouse packet tracker
package ps2mt_pkg;

  localparam int COORD_BITS = 13;
  localparam int SIZE_W = 14;
  localparam int POS_W = COORD_BITS + 2;
  localparam int LIM_W = (COORD_BITS + 2 > SIZE_W + 1) ? COORD_BITS + 2 : SIZE_W + 1;
  localparam int COORD_LIMIT = 1 << COORD_BITS;

  localparam int RESET_WIDTH = 1024;
  localparam int RESET_HEIGHT = 768;

  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam logic [7:0] HDR_ALWAYS_ONE = 8'h08;
  localparam logic [7:0] HDR_X_SIGN = 8'h10;
  localparam logic [7:0] HDR_Y_SIGN = 8'h20;
  localparam logic [7:0] HDR_OVERFLOW = 8'hC0;
  localparam logic [7:0] HDR_BUTTONS = 8'h07;

  localparam logic REG_SCREEN_WIDTH = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       from_aux;
  } in_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] cursor_x;
    logic [COORD_BITS-1:0] cursor_y;
    logic [2:0]            button_bits;
    logic                  packet_applied;
    logic                  packet_dropped;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] screen_width;
    logic [SIZE_W-1:0] screen_height;
  } cfg_t;

  function automatic logic [COORD_BITS-1:0] max_coord(input logic [SIZE_W-1:0] size);
    logic [LIM_W-1:0] s;
    s = LIM_W'(size);
    if (s == '0) return '0;
    if (s > LIM_W'(COORD_LIMIT)) return '1;
    return COORD_BITS'(s - LIM_W'(1));
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_coord(input logic signed [POS_W-1:0] v,
                                                        input logic [COORD_BITS-1:0] hi);
    if (v < 0) return '0;
    if (v > signed'(POS_W'(hi))) return hi;
    return COORD_BITS'(v);
  endfunction

endpackage

// File: hw/rtl/ps2_mouse_packet_tracker.sv
// top level of the ps/2 mouse packet tracker: input stage, result register, registers
//
// channel   direction  handshake             payload
// in        sink       in_valid / in_stall   in_data   (in_item_t)
// out       source     out_valid / out_stall out_data  (out_item_t)
// cfg       apb slave  psel / penable        paddr, pwdata, prdata
//
// one byte per cycle sustained unless out_stall backs up the result register; each transaction
// waits in the input register and leaves through the result register
// the packet state and cursor update in a single pass between the two registers
// rst is synchronous: cursor at the centre of the reset screen, expecting a header
// out_stall holds the result register and backs up into in_stall only when both
// the input register and the result register are full
module ps2_mouse_packet_tracker
  import ps2mt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t      cfg;
  logic      s1_valid;
  in_item_t  s1_item;
  logic      out_free;
  logic      step;
  out_item_t result;

  assign out_free = !out_valid || !out_stall;
  assign in_stall = s1_valid && !out_free;
  assign step = s1_valid && out_free;

  ps2mt_cfg_regs u_cfg_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ps2mt_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (s1_item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (!in_stall) begin
        s1_valid <= in_valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_item <= in_data;
    end
    if (step) begin
      out_data <= result;
    end
  end

  a_held_item_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !out_free |=> s1_valid && $stable(s1_item))
    else $error("input register lost a waiting transaction");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.packet_applied && out_data.packet_dropped))
    else $error("packet both applied and dropped");

  a_applied_in_bounds: assert property (@(posedge clk) disable iff (rst)
    step && result.packet_applied |->
      result.cursor_x <= max_coord(cfg.screen_width) &&
      result.cursor_y <= max_coord(cfg.screen_height))
    else $error("cursor outside the configured screen");

endmodule

// File: hw/rtl/ps2mt_cfg_regs.sv
// apb register file holding the screen size
module ps2mt_cfg_regs
  import ps2mt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic reg_sel;
  logic wr_en;

  assign pready = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.screen_width <= SIZE_W'(RESET_WIDTH);
      cfg.screen_height <= SIZE_W'(RESET_HEIGHT);
    end else if (wr_en) begin
      case (reg_sel)
        REG_SCREEN_WIDTH:  cfg.screen_width <= pwdata[SIZE_W-1:0];
        REG_SCREEN_HEIGHT: cfg.screen_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SCREEN_WIDTH:  prdata = APB_DW'(cfg.screen_width);
      REG_SCREEN_HEIGHT: prdata = APB_DW'(cfg.screen_height);
      default:           prdata = '0;
    endcase
  end

endmodule

// File: hw/rtl/ps2mt_core.sv
// packet assembly state machine, delta decode and cursor clamping
module ps2mt_core
  import ps2mt_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      step,
  input  in_item_t  item,
  input  cfg_t      cfg,
  output out_item_t result
);

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_XBYTE  = 2'd1,
    PH_YBYTE  = 2'd2
  } phase_t;

  localparam logic [COORD_BITS-1:0] RESET_X = COORD_BITS'(RESET_WIDTH / 2);
  localparam logic [COORD_BITS-1:0] RESET_Y = COORD_BITS'(RESET_HEIGHT / 2);

  phase_t                phase, phase_next;
  logic [7:0]            header_byte, header_byte_next;
  logic [7:0]            x_delta_byte, x_delta_byte_next;
  logic [COORD_BITS-1:0] pos_x, pos_x_next;
  logic [COORD_BITS-1:0] pos_y, pos_y_next;
  logic [2:0]            held_buttons, held_buttons_next;
  logic                  applied, dropped;

  logic signed [8:0]       dx, dy;
  logic signed [POS_W-1:0] nx, ny;

  assign dx = signed'({|(header_byte & HDR_X_SIGN), x_delta_byte});
  assign dy = signed'({|(header_byte & HDR_Y_SIGN), item.rx_byte});
  assign nx = signed'(POS_W'(pos_x)) + POS_W'(dx);
  assign ny = signed'(POS_W'(pos_y)) - POS_W'(dy);

  always_comb begin
    phase_next = phase;
    header_byte_next = header_byte;
    x_delta_byte_next = x_delta_byte;
    pos_x_next = pos_x;
    pos_y_next = pos_y;
    held_buttons_next = held_buttons;
    applied = 1'b0;
    dropped = 1'b0;
    if (item.from_aux) begin
      case (phase)
        PH_XBYTE: begin
          x_delta_byte_next = item.rx_byte;
          phase_next = PH_YBYTE;
        end
        PH_YBYTE: begin
          phase_next = PH_HEADER;
          if (|(header_byte & HDR_OVERFLOW)) begin
            dropped = 1'b1;
          end else begin
            pos_x_next = clamp_coord(nx, max_coord(cfg.screen_width));
            pos_y_next = clamp_coord(ny, max_coord(cfg.screen_height));
            held_buttons_next = header_byte[2:0] & HDR_BUTTONS[2:0];
            applied = 1'b1;
          end
        end
        default: begin
          phase_next = PH_HEADER;
          if (|(item.rx_byte & HDR_ALWAYS_ONE)) begin
            header_byte_next = item.rx_byte;
            phase_next = PH_XBYTE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      header_byte <= '0;
      x_delta_byte <= '0;
      pos_x <= RESET_X;
      pos_y <= RESET_Y;
      held_buttons <= '0;
    end else if (step) begin
      phase <= phase_next;
      header_byte <= header_byte_next;
      x_delta_byte <= x_delta_byte_next;
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
      held_buttons <= held_buttons_next;
    end
  end

  assign result.cursor_x = pos_x_next;
  assign result.cursor_y = pos_y_next;
  assign result.button_bits = held_buttons_next;
  assign result.packet_applied = applied;
  assign result.packet_dropped = dropped;

  a_packet_end_to_header: assert property (@(posedge clk) disable iff (rst)
    step && (applied || dropped) |=> phase == PH_HEADER)
    else $error("packet end did not return to header phase");

  a_non_aux_holds: assert property (@(posedge clk) disable iff (rst)
    step && !item.from_aux |=> $stable(pos_x) && $stable(pos_y) && $stable(phase))
    else $error("non-auxiliary byte changed tracker state");

  a_drop_holds_pos: assert property (@(posedge clk) disable iff (rst)
    step && dropped |=> $stable(pos_x) && $stable(pos_y) && $stable(held_buttons))
    else $error("dropped packet moved the cursor");

endmodule

// File: test/ps2_mouse_packet_tracker_tb.sv
// self-checking testbench for the ps/2 mouse packet tracker: directed table, random packets, apb set-up
module ps2_mouse_packet_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ps2mt_pkg::*;

  localparam int CLK_PERIOD = 8;
  localparam int RESET_CYCLES = 8;
  localparam int IDLE_MAX = 19;
  localparam int HOLD_CYCLES = 100;
  localparam int DRAIN_CYCLES = 8;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int MAX_PRINTED = 40;
  localparam int SIGN_WEIGHT = 256;
  localparam int N_SETTINGS = 8;
  localparam int ITEMS_PER_SETTING = 96;
  localparam int HOLD_SETTING = 4;
  localparam int RANDOM_SETTING = 6;
  localparam int SETTING_W [N_SETTINGS] = '{0, 1, 8192, 16383, 8193, 2, 0, 1024};
  localparam int SETTING_H [N_SETTINGS] = '{0, 1, 8192, 8193, 16383, 3, 0, 768};

  typedef enum logic [1:0] {AWAIT_HEADER, AWAIT_X, AWAIT_Y} pkt_phase_e;

  // byte, aux flag, typed flag, then the typed result (cursor x, cursor y, buttons, applied, dropped)
  typedef struct packed {
    logic [7:0]  rx_byte;
    logic        from_aux;
    logic        typed;
    out_item_t   want;
  } dir_row_t;

  localparam int DIR_N = 24;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    {8'hFF, 1'b0, 1'b1, 13'd512, 13'd384, 3'd0, 1'b0, 1'b0},
    {8'hF7, 1'b1, 1'b1, 13'd512, 13'd384, 3'd0, 1'b0, 1'b0},
    {8'h0F, 1'b1, 1'b1, 13'd512, 13'd384, 3'd0, 1'b0, 1'b0},
    {8'hFF, 1'b1, 1'b1, 13'd512, 13'd384, 3'd0, 1'b0, 1'b0},
    {8'h00, 1'b1, 1'b1, 13'd767, 13'd384, 3'd7, 1'b1, 1'b0},
    {8'h38, 1'b1, 1'b0, 31'd0},
    {8'h55, 1'b0, 1'b0, 31'd0},
    {8'h00, 1'b1, 1'b0, 31'd0},
    {8'h00, 1'b1, 1'b0, 31'd0},
    {8'hC8, 1'b1, 1'b0, 31'd0},
    {8'h12, 1'b1, 1'b0, 31'd0},
    {8'h34, 1'b1, 1'b1, 13'd511, 13'd640, 3'd0, 1'b0, 1'b1},
    {8'h4D, 1'b1, 1'b0, 31'd0},
    {8'hFF, 1'b1, 1'b0, 31'd0},
    {8'hFF, 1'b1, 1'b0, 31'd0},
    {8'h8B, 1'b1, 1'b0, 31'd0},
    {8'h80, 1'b1, 1'b0, 31'd0},
    {8'h7F, 1'b1, 1'b0, 31'd0},
    {8'h08, 1'b1, 1'b0, 31'd0},
    {8'hFF, 1'b1, 1'b0, 31'd0},
    {8'h80, 1'b1, 1'b0, 31'd0},
    {8'h18, 1'b1, 1'b0, 31'd0},
    {8'h01, 1'b1, 1'b0, 31'd0},
    {8'h7F, 1'b1, 1'b0, 31'd0}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  in_item_t          in_data = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_item_t         out_data;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // tracker state as predicted
  pkt_phase_e        trk_phase;
  logic [7:0]        trk_hdr;
  logic [7:0]        trk_xbyte;
  int                trk_x;
  int                trk_y;
  logic [2:0]        trk_btn;
  logic [SIZE_W-1:0] scr_w;
  logic [SIZE_W-1:0] scr_h;

  out_item_t predicted_cursor_q [$];
  int        mismatch_count = 0;
  int        quiet_cycles = 0;
  int        hold_left = 0;
  bit        tx_idle = 1'b1;
  bit        rx_idle = 1'b1;

  ps2_mouse_packet_tracker uut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic int fit_to_screen(int v, logic [SIZE_W-1:0] size);
    int top;
    if (size == '0) top = 0;
    else if (size > COORD_LIMIT) top = COORD_LIMIT - 1;
    else top = int'(size) - 1;
    if (v < 0) return 0;
    if (v > top) return top;
    return v;
  endfunction

  function automatic out_item_t track_byte(in_item_t d);
    out_item_t r;
    int dx;
    int dy;
    r = '0;
    if (d.from_aux) begin
      case (trk_phase)
        AWAIT_X: begin
          trk_xbyte = d.rx_byte;
          trk_phase = AWAIT_Y;
        end
        AWAIT_Y: begin
          trk_phase = AWAIT_HEADER;
          if ((trk_hdr & HDR_OVERFLOW) != 8'h00) begin
            r.packet_dropped = 1'b1;
          end else begin
            dx = int'(trk_xbyte) - (((trk_hdr & HDR_X_SIGN) != 8'h00) ? SIGN_WEIGHT : 0);
            dy = int'(d.rx_byte) - (((trk_hdr & HDR_Y_SIGN) != 8'h00) ? SIGN_WEIGHT : 0);
            trk_x = fit_to_screen(trk_x + dx, scr_w);
            trk_y = fit_to_screen(trk_y - dy, scr_h);
            trk_btn = 3'(trk_hdr & HDR_BUTTONS);
            r.packet_applied = 1'b1;
          end
        end
        default: begin
          trk_phase = AWAIT_HEADER;
          if ((d.rx_byte & HDR_ALWAYS_ONE) != 8'h00) begin
            trk_hdr = d.rx_byte;
            trk_phase = AWAIT_X;
          end
        end
      endcase
    end
    r.cursor_x = COORD_BITS'(trk_x);
    r.cursor_y = COORD_BITS'(trk_y);
    r.button_bits = trk_btn;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatch_count < MAX_PRINTED)
      $display("%0t mismatch: %s got %0d expected %0d", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_byte(in_item_t d, logic typed, out_item_t want);
    int gap;
    out_item_t e;
    gap = tx_idle ? $urandom_range(0, IDLE_MAX) : 0;
    repeat (gap) @(negedge clk) in_valid <= 1'b0;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= d;
    do @(posedge clk); while (in_stall !== 1'b0);
    e = track_byte(d);
    if (typed) e = want;
    predicted_cursor_q.push_back(e);
  endtask

  task automatic send_mouse_byte(logic [7:0] b, logic aux);
    in_item_t d;
    d.rx_byte = b;
    d.from_aux = aux;
    send_byte(d, 1'b0, '0);
  endtask

  // mostly whole packets with random content, some stray and foreign bytes
  task automatic send_random_traffic(inout int aux_sent);
    logic [7:0] hdr;
    int kind;
    kind = $urandom_range(0, 15);
    if (kind < 12) begin
      hdr = 8'($urandom) | HDR_ALWAYS_ONE;
      if ($urandom_range(0, 5) != 0) hdr = hdr & ~HDR_OVERFLOW;
      for (int k = 0; k < 3; k++) begin
        if ($urandom_range(0, 9) == 0) send_mouse_byte(8'($urandom), 1'b0);
        send_mouse_byte((k == 0) ? hdr : 8'($urandom), 1'b1);
      end
      aux_sent += 3;
    end else if (kind < 14) begin
      send_mouse_byte(8'($urandom), 1'b1);
      aux_sent++;
    end else begin
      send_mouse_byte(8'($urandom), 1'b0);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk) in_valid <= 1'b0;
    while (predicted_cursor_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [SIZE_W-1:0] size);
    logic [APB_DW-1:0] word;
    word = $urandom;
    word[SIZE_W-1:0] = size;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_AW'({idx, 2'b00});
    pwdata <= word;
    @(negedge clk) penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (idx == REG_SCREEN_WIDTH) scr_w = size;
    else scr_h = size;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    int aux_sent;
    int w;
    int h;
    in_item_t d;
    trk_phase = AWAIT_HEADER;
    trk_hdr = '0;
    trk_xbyte = '0;
    trk_x = RESET_WIDTH / 2;
    trk_y = RESET_HEIGHT / 2;
    trk_btn = '0;
    scr_w = SIZE_W'(RESET_WIDTH);
    scr_h = SIZE_W'(RESET_HEIGHT);
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    foreach (DIR_ROWS[i]) begin
      d.rx_byte = DIR_ROWS[i].rx_byte;
      d.from_aux = DIR_ROWS[i].from_aux;
      send_byte(d, DIR_ROWS[i].typed, DIR_ROWS[i].want);
    end

    for (int s = 0; s < N_SETTINGS; s++) begin
      wait_drained();
      w = (s == RANDOM_SETTING) ? $urandom_range(1, COORD_LIMIT) : SETTING_W[s];
      h = (s == RANDOM_SETTING) ? $urandom_range(1, COORD_LIMIT) : SETTING_H[s];
      write_reg(REG_SCREEN_WIDTH, SIZE_W'(w));
      write_reg(REG_SCREEN_HEIGHT, SIZE_W'(h));
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      // back-to-back input against a long output hold
      if (s == HOLD_SETTING) begin
        tx_idle = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      aux_sent = 0;
      while (aux_sent < ITEMS_PER_SETTING) send_random_traffic(aux_sent);
    end

    wait_drained();
    if (mismatch_count == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    int gap;
    out_item_t want;
    wait (rst === 1'b0);
    forever begin
      gap = rx_idle ? $urandom_range(0, IDLE_MAX) : 0;
      if (hold_left != 0) begin
        gap = hold_left;
        hold_left = 0;
      end
      repeat (gap) @(negedge clk) out_stall <= 1'b1;
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      if (predicted_cursor_q.size() == 0) begin
        report_mismatch("transaction with nothing expected, cursor_x", out_data.cursor_x, 0);
      end else begin
        want = predicted_cursor_q.pop_front();
        if (out_data.cursor_x !== want.cursor_x)
          report_mismatch("cursor_x", out_data.cursor_x, want.cursor_x);
        if (out_data.cursor_y !== want.cursor_y)
          report_mismatch("cursor_y", out_data.cursor_y, want.cursor_y);
        if (out_data.button_bits !== want.button_bits)
          report_mismatch("button_bits", out_data.button_bits, want.button_bits);
        if (out_data.packet_applied !== want.packet_applied)
          report_mismatch("packet_applied", out_data.packet_applied, want.packet_applied);
        if (out_data.packet_dropped !== want.packet_dropped)
          report_mismatch("packet_dropped", out_data.packet_dropped, want.packet_dropped);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
        (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

endmodule
